>>> hw/rtl/met_pkg.sv
// Shared types, constants and the shading table for the escape-time pixel unit.
// No dependencies; imported by every module of the block.
package met_pkg;

    // Default values for the top-level parameters
    localparam int MAX_ITER_DEF  = 100;
    localparam int FRAC_BITS_DEF = 28;
    localparam int MAX_SIDE_DEF  = 256;

    // Fixed port widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 7;
    localparam int GLYPH_W   = 7;
    localparam int DIGIT_W   = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0]   SIDE_RESET  = 9'd90;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
    localparam logic [DIGIT_W-1:0] DIGIT_LAST  = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOADX,
        ST_DIVX,
        ST_LOADY,
        ST_DIVY,
        ST_CHECK,
        ST_SUM,
        ST_UPD,
        ST_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_pix;
        logic div_load;
        logic sel_y;
        logic div_step;
        logic cap_c;
        logic clr_z;
        logic upd_z;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic div_done;
        logic z_big;
        logic iter_max;
        logic mag_gt4;
    } dp_sts_t;

    // " .:-=+*#%@" indexed by count mod 10
    function automatic logic [GLYPH_W-1:0] shade_char(input logic [DIGIT_W-1:0] digit);
        logic [GLYPH_W-1:0] ch;
        case (digit)
            4'd0:    ch = 7'd32;
            4'd1:    ch = 7'd46;
            4'd2:    ch = 7'd58;
            4'd3:    ch = 7'd45;
            4'd4:    ch = 7'd61;
            4'd5:    ch = 7'd43;
            4'd6:    ch = 7'd42;
            4'd7:    ch = 7'd35;
            4'd8:    ch = 7'd37;
            4'd9:    ch = 7'd64;
            default: ch = 7'd32;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/met_div.sv
// Restoring divider, one quotient bit per cycle while step is high; dividend must be below divisor.
// Depends on met_pkg.
module met_div
    import met_pkg::*;
#(
    parameter int QW = FRAC_BITS_DEF + 3,
    parameter int DW = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          step,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient,
    output logic          done
);

    localparam int CTW = $clog2(QW + 1);

    logic [CTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  dsr_reg, dsr_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [DW:0]    two_r;
    logic           ge;

    assign two_r = {rem_reg, 1'b0};
    assign ge    = two_r >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        quo_next = quo_reg;
        if (load)
        begin
            cnt_next = CTW'(QW);
            rem_next = dividend;
            dsr_next = divisor;
            quo_next = '0;
        end
        else if (step)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? DW'(two_r - {1'b0, dsr_reg}) : DW'(two_r);
            quo_next = {quo_reg[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

>>> hw/rtl/met_mul.sv
// Unsigned multiplier split into four half-width partial products, two register stages.
// Depends on met_pkg.
module met_mul
    import met_pkg::*;
#(
    parameter int AW = FRAC_BITS_DEF + 2
)
(
    input  logic            clk,
    input  logic [AW-1:0]   a,
    input  logic [AW-1:0]   b,
    output logic [2*AW-1:0] p
);

    localparam int H = (AW + 1) / 2;

    logic [2*H-1:0]  a_pad, b_pad;
    logic [2*H-1:0]  pp_hh_reg, pp_hh_next;
    logic [2*H-1:0]  pp_hl_reg, pp_hl_next;
    logic [2*H-1:0]  pp_lh_reg, pp_lh_next;
    logic [2*H-1:0]  pp_ll_reg, pp_ll_next;
    logic [2*AW-1:0] p_reg, p_next;
    logic [4*H-1:0]  sum;

    assign a_pad = (2*H)'(a);
    assign b_pad = (2*H)'(b);

    // stage 1: partial products
    always_comb
    begin
        pp_hh_next = a_pad[2*H-1:H] * b_pad[2*H-1:H];
        pp_hl_next = a_pad[2*H-1:H] * b_pad[H-1:0];
        pp_lh_next = a_pad[H-1:0]   * b_pad[2*H-1:H];
        pp_ll_next = a_pad[H-1:0]   * b_pad[H-1:0];
    end

    // stage 2: recombine
    always_comb
    begin
        sum = {pp_hh_reg, {(2*H){1'b0}}}
            + (((4*H)'(pp_hl_reg) + (4*H)'(pp_lh_reg)) << H)
            + (4*H)'(pp_ll_reg);
        p_next = sum[2*AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        pp_hh_reg <= pp_hh_next;
        pp_hl_reg <= pp_hl_next;
        pp_lh_reg <= pp_lh_next;
        pp_ll_reg <= pp_ll_next;
        p_reg     <= p_next;
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/met_dp.sv
// Datapath: coordinate mapping through the shared divider, z registers, three multipliers.
// Depends on met_pkg, met_div, met_mul.
module met_dp
    import met_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_SIDE  = MAX_SIDE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic [PIX_W-1:0]   pixel_x,
    input  logic [PIX_W-1:0]   pixel_y,
    input  logic [CFG_W-1:0]   frame_width,
    input  logic [CFG_W-1:0]   frame_height,
    output logic [CNT_W-1:0]   iteration_count,
    output logic [GLYPH_W-1:0] glyph
);

    localparam int W    = FRAC_BITS + 4;    // Q4.F
    localparam int PW   = FRAC_BITS + 2;    // |z| <= 2
    localparam int XW   = FRAC_BITS + 6;    // headroom before saturation
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;
    localparam int EW   = CMPW + 4;
    localparam int DW   = SW + 3;
    localparam int QW   = FRAC_BITS + 3;
    localparam int CW   = $clog2(MAX_ITER + 1);

    localparam logic signed [W-1:0]  FX_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  FX_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  FX_TWO  = {2'b00, 2'b10, {FRAC_BITS{1'b0}}};
    localparam logic signed [W-1:0]  FX_NTWO = {3'b111, 1'b0, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+4:0] FX_FOUR = {3'b001, 2'b00, {FRAC_BITS{1'b0}}};
    localparam logic signed [XW-1:0] SAT_HI  = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO  = {3'b111, {(W-1){1'b0}}};

    function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] r);
        logic [CMPW-1:0] v;
        logic [CMPW-1:0] s;
        v = CMPW'(r);
        if (v < CMPW'(2))
            s = CMPW'(2);
        else if (v > CMPW'(MAX_SIDE))
            s = CMPW'(MAX_SIDE);
        else
            s = v;
        return s[SW-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_fx(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_HI)
            r = FX_MAX;
        else if (v < SAT_LO)
            r = FX_MIN;
        else
            r = $signed(v[W-1:0]);
        return r;
    endfunction

    logic [PIX_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic               neg_reg, neg_next, sat_reg, sat_next;
    logic signed [W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;

    // coordinate mapping
    logic [PIX_W-1:0] p_sel;
    logic [SW-1:0]    s_sel;
    logic [CMPW-1:0]  two_p_x, s_x, diff;
    logic [CMPW:0]    m;
    logic             neg, sat;
    logic [QW-1:0]    quotient;
    logic [W-1:0]     mag;
    logic signed [W-1:0] c_val;

    always_comb
    begin
        p_sel   = cmd.sel_y ? py_reg : px_reg;
        s_sel   = cmd.sel_y ? clamp_side(frame_height) : clamp_side(frame_width);
        two_p_x = CMPW'({p_sel, 1'b0});
        s_x     = CMPW'(s_sel);
        neg     = two_p_x < s_x;
        diff    = neg ? (s_x - two_p_x) : (two_p_x - s_x);
        m       = {diff, 1'b0};
        sat     = EW'(m) >= EW'({s_sel, 3'b000});
    end

    // quotient = floor(m * 2^F / s), computed as m * 2^(F+3) / (8s)
    met_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (DW'(m)),
        .divisor  ({s_sel, 3'b000}),
        .quotient (quotient),
        .done     (sts.div_done)
    );

    always_comb
    begin
        mag = W'(quotient);
        if (sat_reg)
            c_val = neg_reg ? FX_MIN : FX_MAX;
        else
            c_val = neg_reg ? $signed(-mag) : $signed(mag);
    end

    // iteration
    logic [W-1:0]        zr_abs, zi_abs;
    logic [2*PW-1:0]     p_rr, p_ii, p_ri;
    logic [FRAC_BITS+3:0] zr2, zi2;
    logic [FRAC_BITS+4:0] sq_sum;
    logic signed [XW-1:0] re_sum, im_sum;
    logic signed [2*PW:0] xmag, xprod, xsh;
    logic                 xneg;

    assign zr_abs = zr_reg[W-1] ? -zr_reg : zr_reg;
    assign zi_abs = zi_reg[W-1] ? -zi_reg : zi_reg;

    met_mul #(.AW (PW)) u_mul_rr (.clk (clk), .a (zr_abs[PW-1:0]), .b (zr_abs[PW-1:0]), .p (p_rr));
    met_mul #(.AW (PW)) u_mul_ii (.clk (clk), .a (zi_abs[PW-1:0]), .b (zi_abs[PW-1:0]), .p (p_ii));
    met_mul #(.AW (PW)) u_mul_ri (.clk (clk), .a (zr_abs[PW-1:0]), .b (zi_abs[PW-1:0]), .p (p_ri));

    always_comb
    begin
        zr2    = p_rr[2*PW-1:FRAC_BITS];
        zi2    = p_ii[2*PW-1:FRAC_BITS];
        sq_sum = (FRAC_BITS+5)'(zr2) + (FRAC_BITS+5)'(zi2);
        re_sum = $signed({2'b00, zr2}) - $signed({2'b00, zi2})
               + $signed({{2{cr_reg[W-1]}}, cr_reg});
        // 2*zr*zi, floor
        xneg   = zr_reg[W-1] ^ zi_reg[W-1];
        xmag   = $signed({1'b0, p_ri});
        xprod  = xneg ? -xmag : xmag;
        xsh    = xprod >>> (FRAC_BITS - 1);
        im_sum = $signed(xsh[XW-1:0]) + $signed({{2{ci_reg[W-1]}}, ci_reg});
    end

    assign sts.z_big    = (zr_reg > FX_TWO) || (zr_reg < FX_NTWO)
                       || (zi_reg > FX_TWO) || (zi_reg < FX_NTWO);
    assign sts.mag_gt4  = sq_sum > FX_FOUR;
    assign sts.iter_max = (count_reg == CW'(MAX_ITER));

    always_comb
    begin
        px_next    = px_reg;
        py_next    = py_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        digit_next = digit_reg;
        if (cmd.load_pix)
        begin
            px_next = pixel_x;
            py_next = pixel_y;
        end
        if (cmd.div_load)
        begin
            neg_next = neg;
            sat_next = sat;
        end
        if (cmd.cap_c)
        begin
            if (cmd.sel_y)
                ci_next = c_val;
            else
                cr_next = c_val;
        end
        if (cmd.clr_z)
        begin
            zr_next    = '0;
            zi_next    = '0;
            count_next = '0;
            digit_next = '0;
        end
        else if (cmd.upd_z)
        begin
            zr_next    = sat_fx(re_sum);
            zi_next    = sat_fx(im_sum);
            count_next = count_reg + 1'b1;
            digit_next = (digit_reg == DIGIT_LAST) ? '0 : digit_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        neg_reg   <= neg_next;
        sat_reg   <= sat_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        count_reg <= count_next;
        digit_reg <= digit_next;
    end

    assign iteration_count = CNT_W'(count_reg);
    assign glyph           = sts.iter_max ? GLYPH_SPACE : shade_char(digit_reg);

endmodule

>>> hw/rtl/met_ctrl.sv
// Controller state machine: sequences mapping, divisions and the z iteration loop.
// Depends on met_pkg.
module met_ctrl
    import met_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_LOADX;
            ST_LOADX: state_next = ST_DIVX;
            ST_DIVX:  if (sts.div_done) state_next = ST_LOADY;
            ST_LOADY: state_next = ST_DIVY;
            ST_DIVY:  if (sts.div_done) state_next = ST_CHECK;
            ST_CHECK: state_next = (sts.z_big || sts.iter_max) ? ST_DONE : ST_SUM;
            ST_SUM:   state_next = ST_UPD;
            ST_UPD:   state_next = sts.mag_gt4 ? ST_DONE : ST_CHECK;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                cmd.load_pix = start;
            end
            ST_LOADX:
            begin
                cmd.div_load = 1'b1;
            end
            ST_DIVX:
            begin
                cmd.cap_c    = sts.div_done;
                cmd.div_step = !sts.div_done;
            end
            ST_LOADY:
            begin
                cmd.sel_y    = 1'b1;
                cmd.div_load = 1'b1;
            end
            ST_DIVY:
            begin
                cmd.sel_y    = 1'b1;
                cmd.cap_c    = sts.div_done;
                cmd.clr_z    = sts.div_done;
                cmd.div_step = !sts.div_done;
            end
            ST_UPD:
            begin
                cmd.upd_z = !sts.mag_gt4;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/mandelbrot_escape_time_pixel_unit.sv
// Top level of the escape-time pixel unit: configuration registers, controller, datapath.
// Depends on met_pkg, met_ctrl, met_dp.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-----------------------------------
//  pixel   | start, busy, pixel_x, pixel_y            | beat taken when start && !busy
//  result  | done, iteration_count, glyph             | one-cycle strobe, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | beat taken when valid && ready
//
// One pixel at a time. The shared restoring divider handles each coordinate in turn
// (load, FRAC_BITS+3 quotient bits, capture), and each z step passes through the split
// multipliers (partial products, recombine, add/compare/update). The loop stops at the
// bound check or when |z|^2 > 4.
// Reset clears the controller and the divider counter; frame sizes return to 90.
// The result strobe cannot be stalled; busy stays high through the strobe cycle.
module mandelbrot_escape_time_pixel_unit
    import met_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_SIDE  = MAX_SIDE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel in
    input  logic                 start,
    output logic                 busy,
    input  logic [PIX_W-1:0]     pixel_x,
    input  logic [PIX_W-1:0]     pixel_y,
    // result out
    output logic                 done,
    output logic [CNT_W-1:0]     iteration_count,
    output logic [GLYPH_W-1:0]   glyph,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    // Writes are always taken; software only writes while the unit is idle, a rule the block itself does not enforce.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr && (cfg_index == REG_FRAME_WIDTH))
            frame_width_next = cfg_data;
        if (cfg_wr && (cfg_index == REG_FRAME_HEIGHT))
            frame_height_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= SIDE_RESET;
            frame_height_reg <= SIDE_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // sequencing
    met_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // arithmetic; result fields are held stable from the last update through the strobe
    met_dp #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS),
        .MAX_SIDE  (MAX_SIDE)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .frame_width     (frame_width_reg),
        .frame_height    (frame_height_reg),
        .iteration_count (iteration_count),
        .glyph           (glyph)
    );

endmodule

>>> hw/rtl/met_checker.sv
// Port-level checks for the escape-time pixel unit, bound to the top level.
// Depends on met_pkg and mandelbrot_escape_time_pixel_unit.
module met_checker
    import met_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [GLYPH_W-1:0] glyph
);

    // an accepted pixel makes the unit busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy did not rise after accepted pixel");

    // a result only appears while a pixel is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");

    // exactly one result beat per pixel
    assert property (@(posedge clk) disable iff (!rst_n) done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // the unit only goes idle by delivering a result
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // glyph is one of the shading characters
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (glyph == 7'd32 || glyph == 7'd46 || glyph == 7'd58 || glyph == 7'd45 ||
                  glyph == 7'd61 || glyph == 7'd43 || glyph == 7'd42 || glyph == 7'd35 ||
                  glyph == 7'd37 || glyph == 7'd64))
        else $error("glyph outside shading set");

endmodule

bind mandelbrot_escape_time_pixel_unit met_checker u_met_checker (.*);
